### rtl/cnsl_pkg.sv
package cnsl_pkg;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_LOADED   = 2'd0;
  localparam logic [1:0] ST_RUN_DONE = 2'd1;
  localparam logic [1:0] ST_READ     = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_A_LOW    = 3'd0;
  localparam logic [2:0] REG_A_HIGH   = 3'd1;
  localparam logic [2:0] REG_B_LOW    = 3'd2;
  localparam logic [2:0] REG_B_HIGH   = 3'd3;
  localparam logic [2:0] REG_TWEAK    = 3'd4;
  localparam logic [2:0] REG_PASSES   = 3'd5;
  localparam logic [2:0] REG_MASK     = 3'd6;
  localparam logic [2:0] REG_VARIANT  = 3'd7;

  // Byte-11 tweak lookup constant of variant 1.
  localparam logic [19:0] TWEAK_TABLE = 20'h75310;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_READ_ADDR,
    S_READ_OUT,
    S_RUN_INIT,
    S_P_RD,
    S_P_WAIT,
    S_AES,
    S_P_WR,
    S_Q_RD,
    S_Q_WAIT,
    S_MUL,
    S_MUL_ADD,
    S_Q_WR,
    S_DONE
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Doubling in GF(2^8).
  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns, AddRoundKey.
  function automatic logic [127:0] aes_round(input logic [127:0] blk,
                                             input logic [127:0] key);
    logic [7:0] r [16];
    logic [7:0] s0, s1, s2, s3, t;
    logic [127:0] o;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        r[4*col+row] = SBOX[blk[8*(4*((col+row)%4)+row) +: 8]];
      end
    end
    for (int col = 0; col < 4; col++) begin
      s0 = r[4*col]; s1 = r[4*col+1]; s2 = r[4*col+2]; s3 = r[4*col+3];
      t = s0 ^ s1 ^ s2 ^ s3;
      r[4*col]   = s0 ^ t ^ xt(s0 ^ s1);
      r[4*col+1] = s1 ^ t ^ xt(s1 ^ s2);
      r[4*col+2] = s2 ^ t ^ xt(s2 ^ s3);
      r[4*col+3] = s3 ^ t ^ xt(s3 ^ s0);
    end
    for (int i = 0; i < 16; i++) begin
      o[8*i +: 8] = r[i] ^ key[8*i +: 8];
    end
    aes_round = o;
  endfunction

endpackage

### rtl/cryptonight_scratchpad_loop_top.sv
// Load: S_LOAD, S_DONE, then out_valid. Read: S_READ_ADDR, S_READ_OUT (registered memory read), S_DONE.
// Run: S_RUN_INIT, then two rounds per pass; each round walks one shared memory port
// (read p, write p, read q, write q) plus one AES stage and four 32x32 products.
// busy is high from start until the result strobe; one transaction at a time.
// rst_n is synchronous; it clears control state and config to reset values.
// The scratchpad is not cleared; results go out for one cycle and cannot be stalled.
module cryptonight_scratchpad_loop_top #(
  parameter int SCRATCH_BLOCKS = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [16:0] in_block_index,
  input  logic [63:0] in_data_low,
  input  logic [63:0] in_data_high,
  output logic        out_valid,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cnsl_pkg::*;

  localparam int AW = (SCRATCH_BLOCKS > 1) ? $clog2(SCRATCH_BLOCKS) : 1;

  // Configuration registers.
  logic [63:0] a_low_r, a_high_r, b_low_r, b_high_r, tweak_r;
  logic [18:0] passes_r;
  logic [20:0] mask_r;
  logic        variant_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_low_r <= '0; a_high_r <= '0; b_low_r <= '0; b_high_r <= '0;
      tweak_r <= '0; passes_r <= 19'd262144; mask_r <= 21'd2097136; variant_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_A_LOW:   a_low_r   <= cfg_data;
        REG_A_HIGH:  a_high_r  <= cfg_data;
        REG_B_LOW:   b_low_r   <= cfg_data;
        REG_B_HIGH:  b_high_r  <= cfg_data;
        REG_TWEAK:   tweak_r   <= cfg_data;
        REG_PASSES:  passes_r  <= cfg_data[18:0];
        REG_MASK:    mask_r    <= cfg_data[20:0];
        REG_VARIANT: variant_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Scratchpad memory, one 128-bit port with registered read data.
  logic [127:0] mem [SCRATCH_BLOCKS];
  logic [127:0] rd_r;
  logic         mem_we;
  logic [AW-1:0] mem_addr;
  logic [127:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_r <= mem[mem_addr];
  end

  // Datapath registers.
  state_t state_r, state_nxt;
  logic [127:0] a_r, b_r, c_r, aes_r, blk_r;
  logic [18:0]  pass_r;
  logic         half_r;
  logic [AW-1:0] addr_r;
  logic [1:0]   cmd_r;
  logic [63:0]  pll_r, plh_r, phl_r, phh_r;

  function automatic logic [AW-1:0] blk_of(input logic [63:0] addr,
                                           input logic [20:0] mask);
    logic [20:0] m;
    m = addr[20:0] & mask;
    blk_of = AW'(m[20:4]);
  endfunction

  // Round arithmetic.
  logic [127:0] other, stored_p;
  logic [7:0]   tb;
  logic [4:0]   sh;
  logic [19:0]  tsh;
  logic [63:0]  mid, hi, lo, q0, q1;
  always_comb begin
    other = half_r ? c_r : b_r;
    stored_p = aes_r ^ other;
    tb = stored_p[95:88];
    sh = {1'b0, tb[5:4], tb[0], 1'b0};
    tsh = TWEAK_TABLE >> sh;
    if (variant_r) stored_p[95:88] = stored_p[95:88] ^ (tsh[7:0] & 8'h30);
    mid = {32'd0, pll_r[63:32]} + {32'd0, plh_r[31:0]} + {32'd0, phl_r[31:0]};
    hi = phh_r + {32'd0, plh_r[63:32]} + {32'd0, phl_r[63:32]} + {32'd0, mid[63:32]};
    lo = {mid[31:0], pll_r[31:0]};
    q0 = hi + a_r[63:0];
    q1 = lo + a_r[127:64];
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority case (in_cmd)
            CMD_LOAD: state_nxt = S_LOAD;
            CMD_RUN:  state_nxt = S_RUN_INIT;
            CMD_READ: state_nxt = S_READ_ADDR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:      state_nxt = S_DONE;
      S_READ_ADDR: state_nxt = S_READ_OUT;
      S_READ_OUT:  state_nxt = S_DONE;
      S_RUN_INIT:  state_nxt = (passes_r == '0) ? S_DONE : S_P_RD;
      S_P_RD:      state_nxt = S_P_WAIT;
      S_P_WAIT:    state_nxt = S_AES;
      S_AES:       state_nxt = S_P_WR;
      S_P_WR:      state_nxt = S_Q_RD;
      S_Q_RD:      state_nxt = S_Q_WAIT;
      S_Q_WAIT:    state_nxt = S_MUL;
      S_MUL:       state_nxt = S_MUL_ADD;
      S_MUL_ADD:   state_nxt = S_Q_WR;
      S_Q_WR:      state_nxt = (half_r && pass_r == passes_r - 19'd1) ? S_DONE : S_P_RD;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Memory control outputs.
  always_comb begin
    mem_we = 1'b0;
    mem_addr = addr_r;
    mem_wdata = blk_r;
    unique case (state_r)
      S_IDLE:  mem_addr = AW'(in_block_index);
      S_LOAD:  mem_we = 1'b1;
      S_P_WR:  begin mem_we = 1'b1; mem_wdata = stored_p; end
      S_Q_WR:  mem_we = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      pass_r <= '0;
      half_r <= 1'b0;
      a_r <= '0; b_r <= '0; c_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          cmd_r <= in_cmd;
          addr_r <= AW'(in_block_index);
          blk_r <= {in_data_high, in_data_low};
        end
        S_READ_OUT: blk_r <= rd_r;
        S_RUN_INIT: begin
          a_r <= {a_high_r, a_low_r};
          b_r <= {b_high_r, b_low_r};
          c_r <= '0;
          pass_r <= '0;
          half_r <= 1'b0;
          addr_r <= blk_of(a_low_r, mask_r);
        end
        S_AES: begin
          aes_r <= aes_round(rd_r, a_r);
          if (half_r) b_r <= aes_round(rd_r, a_r);
          else c_r <= aes_round(rd_r, a_r);
        end
        S_P_WR: addr_r <= blk_of(aes_r[63:0], mask_r);
        S_MUL: begin
          blk_r <= rd_r;
          pll_r <= 64'(aes_r[31:0]) * 64'(rd_r[31:0]);
          plh_r <= 64'(aes_r[31:0]) * 64'(rd_r[63:32]);
          phl_r <= 64'(aes_r[63:32]) * 64'(rd_r[31:0]);
          phh_r <= 64'(aes_r[63:32]) * 64'(rd_r[63:32]);
        end
        S_MUL_ADD: begin
          a_r <= {blk_r[127:64] ^ q1, blk_r[63:0] ^ q0};
          blk_r <= {q1 ^ (variant_r ? tweak_r : 64'd0), q0};
        end
        S_Q_WR: begin
          addr_r <= blk_of(a_r[63:0], mask_r);
          half_r <= ~half_r;
          if (half_r) pass_r <= pass_r + 19'd1;
        end
        default: ;
      endcase
    end
  end

  // Result transaction.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status <= (cmd_r == CMD_LOAD) ? ST_LOADED :
                    (cmd_r == CMD_RUN) ? ST_RUN_DONE : ST_READ;
      out_result_low  <= (cmd_r == CMD_READ) ? blk_r[63:0] : 64'd0;
      out_result_high <= (cmd_r == CMD_READ) ? blk_r[127:64] : 64'd0;
    end
  end

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE) else $error("result outside idle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_LOAD || in_cmd == CMD_RUN || in_cmd == CMD_READ))
    |=> busy) else $error("start not taken");
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_RD) |-> pass_r < passes_r) else $error("pass count overrun");

endmodule

### dv/cryptonight_scratchpad_loop_top_tb.sv
module cryptonight_scratchpad_loop_top_tb;
  import cnsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCKS = 131072;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic [1:0]  status;
  } block_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [16:0] in_block_index;
  logic [63:0] in_data_low;
  logic [63:0] in_data_high;
  logic        out_valid;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  cryptonight_scratchpad_loop_top dut (.*);

  // Mirror of the configuration registers and the block's running state.
  logic [63:0]  m_a_low, m_a_high, m_b_low, m_b_high, m_tweak;
  logic [18:0]  m_passes;
  logic [20:0]  m_mask;
  logic         m_variant;
  logic [127:0] pad_mirror [int];
  logic [127:0] run_a, run_b, run_c;
  int           written_blocks [$];

  block_result_t pending_results [$];
  bit  failed;
  bit  quiet;
  int  items_sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Doubling in GF(2^8) for MixColumns.
  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES encryption round on a little-endian 16-byte block.
  function automatic logic [127:0] aes_enc_round(input logic [127:0] blk,
                                                 input logic [127:0] key);
    logic [7:0] st [16];
    logic [7:0] c0, c1, c2, c3, all;
    logic [127:0] res;
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++)
        st[4*col+row] = SBOX[blk[8*(4*((col+row)%4)+row) +: 8]];
    for (int col = 0; col < 4; col++) begin
      c0 = st[4*col]; c1 = st[4*col+1]; c2 = st[4*col+2]; c3 = st[4*col+3];
      all = c0 ^ c1 ^ c2 ^ c3;
      st[4*col]   = c0 ^ all ^ gf_double(c0 ^ c1);
      st[4*col+1] = c1 ^ all ^ gf_double(c1 ^ c2);
      st[4*col+2] = c2 ^ all ^ gf_double(c2 ^ c3);
      st[4*col+3] = c3 ^ all ^ gf_double(c3 ^ c0);
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = st[i] ^ key[8*i +: 8];
    return res;
  endfunction

  function automatic int block_of(input logic [63:0] addr);
    return int'(((addr & {43'd0, m_mask}) >> 4) % BLOCKS);
  endfunction

  function automatic logic [127:0] pad_read(input int idx);
    return pad_mirror.exists(idx) ? pad_mirror[idx] : 128'd0;
  endfunction

  // One memory-hard round: AES on block at a, store back, then multiply exchange.
  task automatic hash_round(inout logic [127:0] dst, input logic [127:0] other);
    int p_idx, q_idx;
    logic [127:0] p_blk, q_blk, prod;
    logic [7:0]   tb11;
    logic [2:0]   sel;
    logic [63:0]  lo, hi;
    p_idx = block_of(run_a[63:0]);
    dst = aes_enc_round(pad_read(p_idx), run_a);
    p_blk = dst ^ other;
    if (m_variant) begin
      tb11 = p_blk[64+24 +: 8];
      sel = {tb11[5], tb11[4], tb11[0]};
      p_blk[64+24 +: 8] ^= (TWEAK_TABLE >> (2 * sel)) & 8'h30;
    end
    pad_mirror[p_idx] = p_blk;
    q_idx = block_of(dst[63:0]);
    q_blk = pad_read(q_idx);
    prod = {64'd0, dst[63:0]} * {64'd0, q_blk[63:0]};
    lo = prod[63:0] + run_a[127:64];
    hi = prod[127:64] + run_a[63:0];
    run_a = {q_blk[127:64] ^ lo, q_blk[63:0] ^ hi};
    pad_mirror[q_idx] = {m_variant ? lo ^ m_tweak : lo, hi};
  endtask

  // Update the mirror for one accepted transaction and queue its result.
  task automatic predict_item(input logic [1:0] cmd, input logic [16:0] idx,
                              input logic [63:0] dl, input logic [63:0] dh);
    block_result_t r;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        pad_mirror[int'(idx)] = {dh, dl};
        written_blocks.push_back(int'(idx));
        r.status = ST_LOADED;
        pending_results.push_back(r);
      end
      CMD_RUN: begin
        run_a = {m_a_high, m_a_low};
        run_b = {m_b_high, m_b_low};
        run_c = '0;
        for (int i = 0; i < m_passes; i++) begin
          hash_round(run_c, run_b);
          hash_round(run_b, run_c);
        end
        r.status = ST_RUN_DONE;
        pending_results.push_back(r);
      end
      CMD_READ: begin
        {r.high, r.low} = pad_read(int'(idx));
        r.status = ST_READ;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Result checker: compares each strobed result against the oldest prediction.
  always @(posedge clk) begin
    block_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result low=%h high=%h status=%0d", $time,
                 out_result_low, out_result_high, out_status);
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (out_result_low !== e.low) begin
          $display("%0t: result_low expected %h actual %h", $time, e.low, out_result_low);
          failed = 1;
        end
        if (out_result_high !== e.high) begin
          $display("%0t: result_high expected %h actual %h", $time, e.high,
                   out_result_high);
          failed = 1;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          failed = 1;
        end
      end
    end
  end

  // Send one command transaction, sometimes with a random gap ahead of it (never when quiet).
  task automatic send_item(input logic [1:0] cmd, input logic [16:0] idx,
                           input logic [63:0] dl, input logic [63:0] dh);
    if (!quiet && $urandom_range(99) < 31) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        start <= 0;
      end
    end
    forever begin
      @(negedge clk);
      if (!busy) break;
      start <= 0;
    end
    start <= 1;
    in_cmd <= cmd;
    in_block_index <= idx;
    in_data_low <= dl;
    in_data_high <= dh;
    @(posedge clk);
    predict_item(cmd, idx, dl, dh);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain;
    @(negedge clk);
    start <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    bit taken;
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    taken = 0;
    while (!taken) begin
      #1;
      taken = cfg_ready;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end
    case (idx)
      REG_A_LOW:   m_a_low = value;
      REG_A_HIGH:  m_a_high = value;
      REG_B_LOW:   m_b_low = value;
      REG_B_HIGH:  m_b_high = value;
      REG_TWEAK:   m_tweak = value;
      REG_PASSES:  m_passes = value[18:0];
      REG_MASK:    m_mask = value[20:0];
      REG_VARIANT: m_variant = value[0];
      default: ;
    endcase
  endtask

  task automatic cfg_release;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Write every register; the mask covers 2**k blocks plus junk low bits.
  task automatic configure(input int k, input logic [18:0] passes, input bit variant);
    drain();
    cfg_write(REG_A_LOW, rand64());
    cfg_write(REG_A_HIGH, rand64());
    cfg_write(REG_B_LOW, rand64());
    cfg_write(REG_B_HIGH, rand64());
    cfg_write(REG_TWEAK, rand64());
    cfg_write(REG_PASSES, {45'd0, passes});
    cfg_write(REG_MASK, {$urandom, 32'd0} | ((((64'd1 << k) - 1) << 4) | $urandom_range(15)));
    cfg_write(REG_VARIANT, {$urandom, $urandom_range(1) * 2} | variant);
    cfg_release();
  endtask

  // Load every block a run can reach under the current mask.
  task automatic fill_reachable(input int k);
    for (int i = 0; i < (1 << k); i++) send_item(CMD_LOAD, 17'(i), rand64(), rand64());
  endtask

  task automatic read_random_written;
    send_item(CMD_READ, 17'(written_blocks[$urandom_range(written_blocks.size() - 1)]),
              rand64(), rand64());
  endtask

  // Field extremes, every command, unknown command, zero passes, both variants.
  task automatic test_directed;
    send_item(CMD_LOAD, 17'd0, 64'd0, 64'd0);
    send_item(CMD_LOAD, 17'h1ffff, '1, '1);
    send_item(CMD_LOAD, 17'h0aaaa, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(CMD_READ, 17'd0, '1, '1);
    send_item(CMD_READ, 17'h1ffff, 64'd0, 64'd0);
    send_item(CMD_READ, 17'h0aaaa, 64'd0, 64'd0);
    send_item(2'd3, 17'h1ffff, '1, '1);
    send_item(CMD_READ, 17'd0, 64'd0, 64'd0);
    // Zero passes by truncation of an oversized value, full mask.
    drain();
    cfg_write(REG_PASSES, 64'hffff_ffff_fff8_0000);
    cfg_write(REG_MASK, '1);
    cfg_write(REG_VARIANT, 64'd1);
    cfg_release();
    send_item(CMD_RUN, 17'd0, 64'd0, 64'd0);
    // Mask of zero: every address lands on block 0.
    configure(0, 19'd3, 1'b0);
    send_item(CMD_RUN, 17'h1ffff, '1, '1);
    send_item(CMD_READ, 17'd0, 64'd0, 64'd0);
    configure(2, 19'd2, 1'b1);
    fill_reachable(2);
    send_item(CMD_RUN, 17'd0, 64'd0, 64'd0);
    for (int i = 0; i < 4; i++) send_item(CMD_READ, 17'(i), 64'd0, 64'd0);
  endtask

  // Reset-default pass count and largest mask: only loads and reads in this setting.
  task automatic test_config_extremes;
    drain();
    cfg_write(REG_PASSES, 64'd262144);
    cfg_write(REG_MASK, 64'h1f_ffff);
    cfg_write(REG_A_LOW, '1);
    cfg_write(REG_A_HIGH, '1);
    cfg_write(REG_B_LOW, '1);
    cfg_write(REG_B_HIGH, '1);
    cfg_write(REG_TWEAK, '1);
    cfg_write(REG_VARIANT, 64'd0);
    cfg_release();
    repeat (20) send_item(CMD_LOAD, 17'($urandom), rand64(), rand64());
    repeat (10) read_random_written();
  endtask

  // Random settings, each with a burst of loads, runs, reads and unknown commands.
  task automatic test_random_traffic;
    int k, pick, setting;
    setting = 0;
    while (items_sent < 1150) begin
      k = $urandom_range(5);
      quiet = (setting == 3);
      configure(k, ($urandom_range(9) == 0) ? 19'd0 : 19'($urandom_range(1, 6)),
                1'($urandom_range(1)));
      fill_reachable(k);
      repeat (100) begin
        pick = $urandom_range(99);
        if (pick < 20) send_item(CMD_RUN, 17'($urandom), rand64(), rand64());
        else if (pick < 30) send_item(CMD_LOAD, 17'($urandom_range((1 << k) - 1)),
                                      rand64(), rand64());
        else if (pick < 60) send_item(CMD_LOAD, 17'($urandom), rand64(), rand64());
        else if (pick < 95) read_random_written();
        else send_item(2'd3, 17'($urandom), rand64(), rand64());
      end
      if (setting == 1) drain();
      setting++;
    end
    quiet = 0;
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_cmd = CMD_LOAD;
    in_block_index = '0;
    in_data_low = '0;
    in_data_high = '0;
    cfg_valid = 0;
    cfg_index = REG_A_LOW;
    cfg_data = '0;
    failed = 0;
    quiet = 0;
    items_sent = 0;
    m_a_low = '0; m_a_high = '0; m_b_low = '0; m_b_high = '0; m_tweak = '0;
    m_passes = 19'd262144;
    m_mask = 21'd2097136;
    m_variant = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    test_directed();
    test_config_extremes();
    test_random_traffic();

    drain();
    repeat (20) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
